// File: rtl/core/shamd_pkg.sv
// Shared types, round constants, initial hash vector and sigma functions
// for the SHA-256 message digest block. Depends on nothing.
package shamd_pkg;

    typedef logic [31:0] t_word;
    typedef t_word t_hash [8];

    localparam t_hash INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // First padding byte after the message.
    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// File: rtl/core/shamd_round.sv
// One SHA-256 compression round and one message schedule step.
// Depends on shamd_pkg for types and sigma functions.
module shamd_round (
    input  shamd_pkg::t_hash i_v,
    input  shamd_pkg::t_word i_k,
    input  shamd_pkg::t_word i_w0,
    input  shamd_pkg::t_word i_w1,
    input  shamd_pkg::t_word i_w9,
    input  shamd_pkg::t_word i_w14,
    output shamd_pkg::t_hash o_v,
    output shamd_pkg::t_word o_w_next
);

    shamd_pkg::t_word w_t1;
    shamd_pkg::t_word w_t2;
    shamd_pkg::t_word w_ch;
    shamd_pkg::t_word w_maj;

    always_comb begin
        w_ch  = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        w_maj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        w_t1  = i_v[7] + shamd_pkg::big_sigma1(i_v[4]) + w_ch + i_k + i_w0;
        w_t2  = shamd_pkg::big_sigma0(i_v[0]) + w_maj;
        o_v[0] = w_t1 + w_t2;
        o_v[1] = i_v[0];
        o_v[2] = i_v[1];
        o_v[3] = i_v[2];
        o_v[4] = i_v[3] + w_t1;
        o_v[5] = i_v[4];
        o_v[6] = i_v[5];
        o_v[7] = i_v[6];
    end

    // Schedule word sixteen places ahead of the one consumed this round.
    assign o_w_next = shamd_pkg::small_sigma1(i_w14) + i_w9
                    + shamd_pkg::small_sigma0(i_w1) + i_w0;

endmodule

// File: rtl/core/sha256_message_digest_top.sv
// SHA-256 message digest, byte-serial input, word-serial digest output.
// Depends on shamd_pkg and shamd_round.
//
// Usage: present message bytes one request at a time, with i_byte_present
// high; mark the final request with i_message_end (i_byte_present may be low
// on it, which also gives the empty-message digest). A request without byte
// and without end does nothing. After the end request the block pads the
// message, compresses the last one or two blocks and then offers the eight
// digest words, index 0 first, o_last_word on the eighth; it then returns to
// the initial hash vector for the next message. Timing: one byte is taken per
// cycle while o_in_ready is high; every 64th byte starts 64 rounds of the
// single shared round unit and then a fold of the result into the chaining
// words, with no byte taken until both are done. The end request starts the
// padder, one byte per cycle (up to 64 per padded block, up to 72 in all);
// each padded block (one or two, two when 56 or more bytes of the last block
// are in use) gets its rounds and fold, then one digest word goes out per
// cycle while the consumer takes them. o_in_ready is high only while the
// sequencer waits for bytes. The block buffer lives as a 16-word shift line
// that doubles as the message schedule window during the rounds.
module sha256_message_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]       r_state;
    logic [5:0]       r_fill;      // byte position within the current block
    logic [60:0]      r_count;     // message bytes taken, modulo 2^61
    logic [5:0]       r_rnd;
    logic [2:0]       r_oidx;
    logic             r_end;       // end request seen with the block-filling byte
    logic             r_pad;       // padding under way
    logic             r_mark;      // 0x80 already written
    logic             r_arm;       // current block takes the bit length
    shamd_pkg::t_hash r_h;
    shamd_pkg::t_hash r_v;
    shamd_pkg::t_word r_w [16];
    logic [23:0]      r_part;      // bytes of the word being assembled

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_push;
    logic [7:0]       w_byte;
    logic [7:0]       w_pad_byte;
    logic [63:0]      w_len;
    shamd_pkg::t_hash w_v_next;
    shamd_pkg::t_word w_w_next;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;

    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    // Bit length, big-endian in the last eight bytes of the final block.
    assign w_len = {r_count, 3'b000};

    always_comb begin
        if (!r_mark) begin
            w_pad_byte = shamd_pkg::PAD_MARK;
        end else if (r_arm && (&r_fill[5:3])) begin
            w_pad_byte = w_len[{3'd7 - r_fill[2:0], 3'b000} +: 8];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // At most one byte enters the buffer per cycle, from an accepted request or the padder; none during the rounds.
    assign w_push = (w_in_acc && i_byte_present) || (r_state == S_PAD);
    assign w_byte = (r_state == S_PAD) ? w_pad_byte : i_message_byte;

    shamd_round u_round (
        .i_v      (r_v),
        .i_k      (shamd_pkg::ROUND_K[r_rnd]),
        .i_w0     (r_w[0]),
        .i_w1     (r_w[1]),
        .i_w9     (r_w[9]),
        .i_w14    (r_w[14]),
        .o_v      (w_v_next),
        .o_w_next (w_w_next)
    );

    // Buffer and schedule window: shift in a whole word per four bytes,
    // and one schedule word per round.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_part <= {r_part[15:0], w_byte};
            if (r_fill[1:0] == 2'b11) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= {r_part, w_byte};
            end
        end else if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_w_next;
        end
    end

    // Working variables: load from the chaining words, then advance a round.
    always_ff @(posedge i_clk) begin
        if (w_push && (r_fill == 6'd63)) begin
            r_v <= r_h;
        end else if (r_state == S_ROUND) begin
            r_v <= w_v_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            r_end   <= 1'b0;
            r_pad   <= 1'b0;
            r_mark  <= 1'b0;
            r_arm   <= 1'b0;
            r_h     <= shamd_pkg::INIT_HASH;
        end else begin
            if (w_push) begin
                r_fill <= r_fill + 6'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_end <= i_message_end;
                        if (i_byte_present) begin
                            r_count <= r_count + 61'd1;
                        end
                        if (i_byte_present && (r_fill == 6'd63)) begin
                            r_rnd   <= '0;
                            r_state <= S_ROUND;
                        end else if (i_message_end) begin
                            r_pad   <= 1'b1;
                            r_mark  <= 1'b0;
                            r_arm   <= 1'b0;
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (!r_mark) begin
                        r_mark <= 1'b1;
                        // Length fits behind the mark only below position 56.
                        r_arm  <= !(&r_fill[5:3]);
                    end
                    if (r_fill == 6'd63) begin
                        r_rnd   <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (r_pad && r_arm) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else if (r_pad) begin
                        // Mark landed too late: a second block carries the length.
                        r_arm   <= 1'b1;
                        r_state <= S_PAD;
                    end else if (r_end) begin
                        r_pad   <= 1'b1;
                        r_mark  <= 1'b0;
                        r_arm   <= 1'b0;
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        if (r_oidx == 3'd7) begin
                            // Drop the message and restore the initial vector.
                            r_h     <= shamd_pkg::INIT_HASH;
                            r_count <= '0;
                            r_end   <= 1'b0;
                            r_pad   <= 1'b0;
                            r_mark  <= 1'b0;
                            r_arm   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/shamd_checker.sv
// Port-level checks for the SHA-256 message digest block, bound to the top.
// Depends on sha256_message_digest_top.
module shamd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_message_byte,
    input logic        i_byte_present,
    input logic        i_message_end,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // Hold off requests while digest words are on offer.
    a_no_ready_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while digest words pending");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_index_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_word) |=>
        (o_out_valid && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest word sequence broken");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word) |=> (o_in_ready && !o_out_valid))
        else $error("not ready for a new message after the digest");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_digest_word) && $stable(o_word_index)))
        else $error("stalled digest word changed");

endmodule

bind sha256_message_digest_top shamd_checker u_shamd_checker (.*);
